// File: sv/ssef_pkg.sv
package ssef_pkg;

    localparam int RATE_ENTRIES_DEF  = 4096;
    localparam int COUNT_ENTRIES_DEF = 8192;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RATE_INTERVAL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE_FILE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE_NETWORK = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE_MEMORY  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE_PROCESS = 3'd4;

    // syscall kinds
    localparam logic [3:0] KIND_OPEN    = 4'd0;
    localparam logic [3:0] KIND_OPENAT  = 4'd1;
    localparam logic [3:0] KIND_WRITE   = 4'd2;
    localparam logic [3:0] KIND_MMAP    = 4'd3;
    localparam logic [3:0] KIND_BRK     = 4'd4;
    localparam logic [3:0] KIND_CONNECT = 4'd5;
    localparam logic [3:0] KIND_BIND    = 4'd6;
    localparam logic [3:0] KIND_FORK    = 4'd7;
    localparam logic [3:0] KIND_CLONE   = 4'd8;

    // syscall numbers
    localparam logic [8:0] SYS_OPEN    = 9'd2;
    localparam logic [8:0] SYS_OPENAT  = 9'd257;
    localparam logic [8:0] SYS_WRITE   = 9'd1;
    localparam logic [8:0] SYS_MMAP    = 9'd9;
    localparam logic [8:0] SYS_BRK     = 9'd12;
    localparam logic [8:0] SYS_CONNECT = 9'd42;
    localparam logic [8:0] SYS_BIND    = 9'd49;
    localparam logic [8:0] SYS_FORK    = 9'd57;
    localparam logic [8:0] SYS_CLONE   = 9'd56;

    // categories
    localparam logic [2:0] CAT_FILE    = 3'd1;
    localparam logic [2:0] CAT_NETWORK = 3'd2;
    localparam logic [2:0] CAT_MEMORY  = 3'd3;
    localparam logic [2:0] CAT_PROCESS = 3'd4;

    // errno values
    localparam logic [31:0] ERR_NOENT  = 32'd2;
    localparam logic [31:0] ERR_IO     = 32'd5;
    localparam logic [31:0] ERR_AGAIN  = 32'd11;
    localparam logic [31:0] ERR_NOMEM  = 32'd12;
    localparam logic [31:0] ERR_ACCES  = 32'd13;
    localparam logic [31:0] ERR_MFILE  = 32'd24;
    localparam logic [31:0] ERR_NOSPC  = 32'd28;
    localparam logic [63:0] MMAP_ERR_LOW = 64'hFFFF_FFFF_FFFF_F001;

    typedef struct packed {
        logic        hit;
        logic [8:0]  sysno;
        logic [31:0] code;
        logic [2:0]  cat;
    } t_class;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic idx_clr;
        logic rate_rd;
        logic rate_step;
        logic rate_upd;
        logic rate_ins;
        logic cnt_rd;
        logic cnt_step;
        logic cnt_upd;
        logic cnt_ins;
        logic emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic hit;
        logic rate_none;
        logic rate_match;
        logic rate_drop;
        logic rate_end;
        logic cnt_none;
        logic cnt_match;
        logic cnt_end;
    } t_stat;

    // en: {process, memory, network, file}
    function automatic t_class classify(input logic [3:0] kind, input logic [63:0] ret,
                                        input logic [3:0] en);
        t_class      c;
        logic        neg;
        logic [31:0] e;
        neg     = ret[63];
        e       = 32'd0 - ret[31:0];
        c.hit   = 1'b0;
        c.sysno = 9'd0;
        c.code  = ret[31:0];
        c.cat   = 3'd0;
        case (kind)
            KIND_OPEN: begin
                c.hit = en[0] && neg && (e == ERR_NOSPC || e == ERR_MFILE || e == ERR_ACCES);
                c.sysno = SYS_OPEN; c.cat = CAT_FILE;
            end
            KIND_OPENAT: begin
                c.hit = en[0] && neg && (e == ERR_NOSPC || e == ERR_MFILE ||
                                         e == ERR_ACCES || e == ERR_NOENT);
                c.sysno = SYS_OPENAT; c.cat = CAT_FILE;
            end
            KIND_WRITE: begin
                c.hit = en[0] && neg && (e == ERR_NOSPC || e == ERR_IO);
                c.sysno = SYS_WRITE; c.cat = CAT_FILE;
            end
            KIND_MMAP: begin
                c.hit = en[2] && (ret >= MMAP_ERR_LOW);
                c.sysno = SYS_MMAP; c.cat = CAT_MEMORY;
            end
            KIND_BRK: begin
                c.hit = en[2] && (ret == 64'd0);
                c.code = 32'd0 - ERR_NOMEM;
                c.sysno = SYS_BRK; c.cat = CAT_MEMORY;
            end
            KIND_CONNECT: begin
                c.hit = en[1] && neg;
                c.sysno = SYS_CONNECT; c.cat = CAT_NETWORK;
            end
            KIND_BIND: begin
                c.hit = en[1] && neg;
                c.sysno = SYS_BIND; c.cat = CAT_NETWORK;
            end
            KIND_FORK: begin
                c.hit = en[3] && neg && (e == ERR_AGAIN || e == ERR_NOMEM);
                c.sysno = SYS_FORK; c.cat = CAT_PROCESS;
            end
            KIND_CLONE: begin
                c.hit = en[3] && neg;
                c.sysno = SYS_CLONE; c.cat = CAT_PROCESS;
            end
            default: c.hit = 1'b0;
        endcase
        return c;
    endfunction

endpackage

// File: sv/ssef_ram.sv
module ssef_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/ssef_ctrl.sv
module ssef_ctrl
    import ssef_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy
);

    typedef enum logic [2:0] {
        S_IDLE, S_CLASS, S_R_RD, S_R_CMP, S_C_START, S_C_RD, S_C_CMP, S_EMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, n_busy;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CLASS;
                end
            end
            S_CLASS: begin
                o_cmd.idx_clr = 1'b1;
                if (!i_stat.hit) begin
                    n_state = S_IDLE;
                end else if (i_stat.rate_none) begin
                    o_cmd.rate_ins = 1'b1;
                    n_state        = S_C_START;
                end else begin
                    n_state = S_R_RD;
                end
            end
            S_R_RD: begin
                o_cmd.rate_rd = 1'b1;
                n_state       = S_R_CMP;
            end
            S_R_CMP: begin
                if (i_stat.rate_match) begin
                    if (i_stat.rate_drop) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.rate_upd = 1'b1;
                        n_state        = S_C_START;
                    end
                end else if (i_stat.rate_end) begin
                    o_cmd.rate_ins = 1'b1;
                    n_state        = S_C_START;
                end else begin
                    o_cmd.rate_step = 1'b1;
                    n_state         = S_R_RD;
                end
            end
            S_C_START: begin
                o_cmd.idx_clr = 1'b1;
                if (i_stat.cnt_none) begin
                    o_cmd.cnt_ins = 1'b1;
                    n_state       = S_EMIT;
                end else begin
                    n_state = S_C_RD;
                end
            end
            S_C_RD: begin
                o_cmd.cnt_rd = 1'b1;
                n_state      = S_C_CMP;
            end
            S_C_CMP: begin
                if (i_stat.cnt_match) begin
                    o_cmd.cnt_upd = 1'b1;
                    n_state       = S_EMIT;
                end else if (i_stat.cnt_end) begin
                    o_cmd.cnt_ins = 1'b1;
                    n_state       = S_EMIT;
                end else begin
                    o_cmd.cnt_step = 1'b1;
                    n_state        = S_C_RD;
                end
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                n_state    = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        n_busy = (n_state != S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

    assign o_busy = r_busy;

endmodule

// File: sv/ssef_dp.sv
module ssef_dp
    import ssef_pkg::*;
#(
    parameter int RATE_ENTRIES  = RATE_ENTRIES_DEF,
    parameter int COUNT_ENTRIES = COUNT_ENTRIES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [3:0]            i_syscall_kind,
    input  logic [63:0]           i_return_value,
    input  logic [31:0]           i_process_id,
    input  logic [63:0]           i_now_time,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    output logic                  o_valid,
    output logic [31:0]           o_event_pid,
    output logic [63:0]           o_event_time,
    output logic [8:0]            o_syscall_number,
    output logic [31:0]           o_err_code,
    output logic [2:0]            o_category,
    output logic [31:0]           o_fail_count
);

    localparam int RAW = (RATE_ENTRIES > 1) ? $clog2(RATE_ENTRIES) : 1;
    localparam int RFW = $clog2(RATE_ENTRIES + 1);
    localparam int CAW = (COUNT_ENTRIES > 1) ? $clog2(COUNT_ENTRIES) : 1;
    localparam int CFW = $clog2(COUNT_ENTRIES + 1);
    localparam int RW  = 32 + 64;
    localparam int CW  = 32 + 9 + 32 + 32;

    logic [31:0]  r_interval;
    logic [3:0]   r_en;
    logic [RFW-1:0] r_rfill;
    logic [CFW-1:0] r_cfill;
    logic [RAW-1:0] r_ridx;
    logic [CAW-1:0] r_cidx;
    logic [31:0]  r_pid;
    logic [63:0]  r_now;
    t_class       r_cls;
    logic [31:0]  r_count;
    logic         r_valid;

    logic          rate_room, cnt_room;
    logic          rate_we, cnt_we;
    logic [RW-1:0] rate_rdata;
    logic [CW-1:0] cnt_rdata;
    logic [31:0]   cnt_inc;
    logic [63:0]   elapsed;

    assign rate_room = (r_rfill != RFW'(RATE_ENTRIES));
    assign cnt_room  = (r_cfill != CFW'(COUNT_ENTRIES));
    assign rate_we   = i_cmd.rate_upd | (i_cmd.rate_ins & rate_room);
    assign cnt_we    = i_cmd.cnt_upd | (i_cmd.cnt_ins & cnt_room);

    // rate entry: pid, last time
    ssef_ram #(.WIDTH(RW), .DEPTH(RATE_ENTRIES)) u_rate_ram (
        .i_clk   (i_clk),
        .i_we    (rate_we),
        .i_waddr (i_cmd.rate_upd ? r_ridx : r_rfill[RAW-1:0]),
        .i_wdata ({r_pid, r_now}),
        .i_re    (i_cmd.rate_rd),
        .i_raddr (r_ridx),
        .o_rdata (rate_rdata)
    );

    // count entry: pid, sysno, code, total
    ssef_ram #(.WIDTH(CW), .DEPTH(COUNT_ENTRIES)) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (i_cmd.cnt_upd ? r_cidx : r_cfill[CAW-1:0]),
        .i_wdata ({r_pid, r_cls.sysno, r_cls.code, i_cmd.cnt_upd ? cnt_inc : 32'd1}),
        .i_re    (i_cmd.cnt_rd),
        .i_raddr (r_cidx),
        .o_rdata (cnt_rdata)
    );

    assign elapsed = r_now - rate_rdata[63:0];
    assign cnt_inc = (cnt_rdata[31:0] == 32'hFFFF_FFFF) ? cnt_rdata[31:0]
                                                         : cnt_rdata[31:0] + 32'd1;

    always_comb begin
        o_stat.hit        = r_cls.hit;
        o_stat.rate_none  = (r_rfill == '0);
        o_stat.rate_match = (rate_rdata[95:64] == r_pid);
        o_stat.rate_drop  = (elapsed < {32'd0, r_interval});
        o_stat.rate_end   = ((RFW'(r_ridx) + RFW'(1)) == r_rfill);
        o_stat.cnt_none   = (r_cfill == '0);
        o_stat.cnt_match  = (cnt_rdata[104:73] == r_pid) &&
                            (cnt_rdata[72:64] == r_cls.sysno) &&
                            (cnt_rdata[63:32] == r_cls.code);
        o_stat.cnt_end    = ((CFW'(r_cidx) + CFW'(1)) == r_cfill);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= '0;
            r_en       <= '0;
            r_rfill    <= '0;
            r_cfill    <= '0;
            r_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_RATE_INTERVAL:  r_interval <= i_cfg_data;
                    REG_ENABLE_FILE:    r_en[0]    <= i_cfg_data[0];
                    REG_ENABLE_NETWORK: r_en[1]    <= i_cfg_data[0];
                    REG_ENABLE_MEMORY:  r_en[2]    <= i_cfg_data[0];
                    REG_ENABLE_PROCESS: r_en[3]    <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cmd.rate_ins && rate_room) begin
                r_rfill <= r_rfill + RFW'(1);
            end
            if (i_cmd.cnt_ins && cnt_room) begin
                r_cfill <= r_cfill + CFW'(1);
            end
            r_valid <= i_cmd.emit;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pid <= i_process_id;
            r_now <= i_now_time;
            r_cls <= classify(i_syscall_kind, i_return_value, r_en);
        end
        if (i_cmd.idx_clr) begin
            r_ridx <= '0;
            r_cidx <= '0;
        end
        if (i_cmd.rate_step) begin
            r_ridx <= r_ridx + RAW'(1);
        end
        if (i_cmd.cnt_step) begin
            r_cidx <= r_cidx + CAW'(1);
        end
        if (i_cmd.cnt_upd) begin
            r_count <= cnt_inc;
        end else if (i_cmd.cnt_ins) begin
            r_count <= 32'd1;
        end
    end

    assign o_valid          = r_valid;
    assign o_event_pid      = r_pid;
    assign o_event_time     = r_now;
    assign o_syscall_number = r_cls.sysno;
    assign o_err_code       = r_cls.code;
    assign o_category       = r_cls.cat;
    assign o_fail_count     = r_count;

endmodule

// File: sv/syscall_error_event_filter.sv
// channel   | handshake                     | payload
// ----------+-------------------------------+-----------------------------------------
// input     | i_start, o_busy (start&!busy) | i_syscall_kind, i_return_value, ...
// result    | o_valid, one-cycle strobe     | o_event_pid, o_event_time, ... o_fail_count
// config    | i_cfg_we                      | i_cfg_idx, i_cfg_data
//
// one beat at a time: busy holds until the item is done; an item that is no reportable
// failure ends after its classification, one dropped by the rate check after the rate
// search; a reported one strobes its result after the rate search and then the count
// search, each a linear search over its table (one read port; each entry is read, then
// compared); busy drops in the strobe cycle
// synchronous active-low reset; tables fill in order, so fill counts stand in for
// valid bits and no clearing pass is needed
// the result strobe lasts one cycle and the receiver cannot stall it
module syscall_error_event_filter
    import ssef_pkg::*;
#(
    parameter int RATE_ENTRIES  = RATE_ENTRIES_DEF,
    parameter int COUNT_ENTRIES = COUNT_ENTRIES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_start,
    output logic                  o_busy,
    input  logic [3:0]            i_syscall_kind,
    input  logic signed [63:0]    i_return_value,
    input  logic [31:0]           i_process_id,
    input  logic [63:0]           i_now_time,
    output logic                  o_valid,
    output logic [31:0]           o_event_pid,
    output logic [63:0]           o_event_time,
    output logic [8:0]            o_syscall_number,
    output logic signed [31:0]    o_err_code,
    output logic [2:0]            o_category,
    output logic [31:0]           o_fail_count
);

    t_cmd  cmd;
    t_stat stat;
    logic [31:0] err_code_raw;

    // sequencer: classify, rate search, count search, emit
    ssef_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    // config registers, tables and result registers
    ssef_dp #(
        .RATE_ENTRIES  (RATE_ENTRIES),
        .COUNT_ENTRIES (COUNT_ENTRIES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_syscall_kind   (i_syscall_kind),
        .i_return_value   ($unsigned(i_return_value)),
        .i_process_id     (i_process_id),
        .i_now_time       (i_now_time),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .o_valid          (o_valid),
        .o_event_pid      (o_event_pid),
        .o_event_time     (o_event_time),
        .o_syscall_number (o_syscall_number),
        .o_err_code       (err_code_raw),
        .o_category       (o_category),
        .o_fail_count     (o_fail_count)
    );

    assign o_err_code = $signed(err_code_raw);

endmodule

// File: sv/ssef_chk.sv
module ssef_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_start,
    input logic       o_busy,
    input logic       o_valid,
    input logic [2:0] o_category,
    input logic [31:0] o_fail_count
);

    // a result only follows a busy period
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(o_busy)) else $error("result without busy period");

    // one beat per item, never back to back
    a_valid_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe longer than a cycle");

    a_category: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_category == 3'd1 || o_category == 3'd2 ||
                     o_category == 3'd3 || o_category == 3'd4))
        else $error("bad category");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_fail_count != 32'd0)) else $error("zero failure count");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy) else $error("accepted item not busy");

endmodule

bind syscall_error_event_filter ssef_chk u_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_start      (i_start),
    .o_busy       (o_busy),
    .o_valid      (o_valid),
    .o_category   (o_category),
    .o_fail_count (o_fail_count)
);
